/* hw/rtl/line_follow_pd_drive_core_macros.svh */
// assertion helpers used by the core top level, clocked on clk with async reset rst_n
`ifndef LINE_FOLLOW_PD_DRIVE_CORE_MACROS_SVH
`define LINE_FOLLOW_PD_DRIVE_CORE_MACROS_SVH

// same-cycle implication
`define LFPD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfpd same-cycle check failed");

// next-cycle implication
`define LFPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfpd next-cycle check failed");

`endif

/* hw/rtl/lfpd_pkg.sv */
package lfpd_pkg;

    localparam int SAMPLE_BITS_DEF   = 10;
    localparam int CONFIRM_TICKS_DEF = 5;

    localparam int ERR_BITS   = 20;
    localparam int DRIVE_BITS = 9;
    localparam int GAIN_BITS  = 16;
    localparam int SPEED_BITS = 8;
    localparam int COUNT_BITS = 3;
    localparam int ADDR_BITS  = 5;
    localparam int DATA_BITS  = 32;

    localparam int OUT_TDATA_BITS = ((2 * DRIVE_BITS + 7) / 8) * 8;

    localparam int DRIVE_MAX         = 255;
    localparam int DEAD_ZONE_REG     = 1280;
    localparam int DEAD_ZONE_BUILTIN = 512;

    // sensor thresholds at 10-bit samples
    localparam int TH_DARK  = 250;
    localparam int TH_LIGHT = 400;
    localparam int TH_CROSS = 330;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_LINE_POLARITY = 3'd0;
    localparam logic [2:0] REG_BASE_SPEED    = 3'd1;
    localparam logic [2:0] REG_PROP_GAIN     = 3'd2;
    localparam logic [2:0] REG_DERIV_GAIN    = 3'd3;
    localparam logic [2:0] REG_GAIN_SOURCE   = 3'd4;
    localparam logic [2:0] REG_STOP_MODE     = 3'd5;

    // stop modes
    localparam logic [1:0] STOP_NEVER = 2'd0;
    localparam logic [1:0] STOP_LEFT  = 2'd1;
    localparam logic [1:0] STOP_RIGHT = 2'd2;
    localparam logic [1:0] STOP_CROSS = 2'd3;

    typedef struct packed {
        logic                  line_polarity;
        logic [SPEED_BITS-1:0] base_speed;
        logic [GAIN_BITS-1:0]  prop_gain;
        logic [GAIN_BITS-1:0]  deriv_gain;
        logic                  gain_source;
        logic [1:0]            stop_mode;
    } cfg_t;

    typedef struct packed {
        logic halt;     // this beat stops the drives
        logic latched;  // stop already latched before this beat
    } stop_status_t;

    // built-in speed-banded gains, q8.8
    function automatic logic [GAIN_BITS-1:0] builtin_kp(input logic [SPEED_BITS-1:0] speed);
        logic [GAIN_BITS-1:0] kp;
        if (speed <= SPEED_BITS'(64))
            kp = GAIN_BITS'(38);
        else if (speed <= SPEED_BITS'(128))
            kp = GAIN_BITS'(77);
        else
            kp = GAIN_BITS'(141);
        return kp;
    endfunction

    function automatic logic [GAIN_BITS-1:0] builtin_kd(input logic [SPEED_BITS-1:0] speed,
                                                        input logic polarity);
        logic [GAIN_BITS-1:0] kd;
        if (speed <= SPEED_BITS'(64))
            kd = polarity ? GAIN_BITS'(1024) : GAIN_BITS'(768);
        else if (speed <= SPEED_BITS'(128))
            kd = polarity ? GAIN_BITS'(2304) : GAIN_BITS'(1536);
        else
            kd = polarity ? GAIN_BITS'(4608) : GAIN_BITS'(3072);
        return kd;
    endfunction

endpackage

/* hw/rtl/lfpd_regs.sv */
module lfpd_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lfpd_pkg::ADDR_BITS-1:0] paddr,
    input  logic [lfpd_pkg::DATA_BITS-1:0] pwdata,
    output logic [lfpd_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    output lfpd_pkg::cfg_t                cfg
);

    lfpd_pkg::cfg_t cfg_reg;
    logic [2:0]     index;
    logic           wr_en;

    assign index  = paddr[lfpd_pkg::ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (index)
                lfpd_pkg::REG_LINE_POLARITY: cfg_reg.line_polarity <= pwdata[0];
                lfpd_pkg::REG_BASE_SPEED:    cfg_reg.base_speed    <= pwdata[7:0];
                lfpd_pkg::REG_PROP_GAIN:     cfg_reg.prop_gain     <= pwdata[15:0];
                lfpd_pkg::REG_DERIV_GAIN:    cfg_reg.deriv_gain    <= pwdata[15:0];
                lfpd_pkg::REG_GAIN_SOURCE:   cfg_reg.gain_source   <= pwdata[0];
                lfpd_pkg::REG_STOP_MODE:     cfg_reg.stop_mode     <= pwdata[1:0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            lfpd_pkg::REG_LINE_POLARITY: prdata = 32'(cfg_reg.line_polarity);
            lfpd_pkg::REG_BASE_SPEED:    prdata = 32'(cfg_reg.base_speed);
            lfpd_pkg::REG_PROP_GAIN:     prdata = 32'(cfg_reg.prop_gain);
            lfpd_pkg::REG_DERIV_GAIN:    prdata = 32'(cfg_reg.deriv_gain);
            lfpd_pkg::REG_GAIN_SOURCE:   prdata = 32'(cfg_reg.gain_source);
            lfpd_pkg::REG_STOP_MODE:     prdata = 32'(cfg_reg.stop_mode);
            default:                     prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/lfpd_stop.sv */
module lfpd_stop #(
    parameter int SAMPLE_BITS   = lfpd_pkg::SAMPLE_BITS_DEF,
    parameter int CONFIRM_TICKS = lfpd_pkg::CONFIRM_TICKS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lfpd_pkg::cfg_t           cfg,
    input  logic [SAMPLE_BITS-1:0]   left_sample,
    input  logic [SAMPLE_BITS-1:0]   right_sample,
    input  logic                     sample_tick,
    input  logic                     step,
    output lfpd_pkg::stop_status_t   status
);

    localparam int CW = SAMPLE_BITS + 10;
    localparam logic [CW-1:0] TH_DARK_W  = CW'(lfpd_pkg::TH_DARK)  << SAMPLE_BITS;
    localparam logic [CW-1:0] TH_LIGHT_W = CW'(lfpd_pkg::TH_LIGHT) << SAMPLE_BITS;
    localparam logic [CW-1:0] TH_CROSS_W = CW'(lfpd_pkg::TH_CROSS) << SAMPLE_BITS;
    localparam logic [lfpd_pkg::COUNT_BITS-1:0] COUNT_TOP  = '1;
    localparam logic [lfpd_pkg::COUNT_BITS-1:0] CONFIRM_CT =
        lfpd_pkg::COUNT_BITS'(CONFIRM_TICKS);

    logic [lfpd_pkg::COUNT_BITS-1:0] count_reg, count_next;
    logic                            latched_reg;
    logic [CW-1:0]                   ls_w, rs_w, js_w;
    logic                            junction_mode, seen, cross_seen, set_stop;

    assign ls_w = {left_sample, 10'b0};
    assign rs_w = {right_sample, 10'b0};
    assign js_w = (cfg.stop_mode == lfpd_pkg::STOP_LEFT) ? ls_w : rs_w;

    assign junction_mode = (cfg.stop_mode == lfpd_pkg::STOP_LEFT) ||
                           (cfg.stop_mode == lfpd_pkg::STOP_RIGHT);

    assign seen       = cfg.line_polarity ? (js_w > TH_LIGHT_W) : (js_w < TH_DARK_W);
    assign cross_seen = cfg.line_polarity ? ((ls_w > TH_CROSS_W) && (rs_w > TH_CROSS_W))
                                          : ((ls_w < TH_CROSS_W) && (rs_w < TH_CROSS_W));

    // saturating run counter of junction ticks
    always_comb
    begin
        if (!seen)
            count_next = '0;
        else if (count_reg == COUNT_TOP)
            count_next = count_reg;
        else
            count_next = count_reg + lfpd_pkg::COUNT_BITS'(1);
    end

    assign set_stop = !latched_reg &&
                      ((junction_mode && sample_tick && (count_next >= CONFIRM_CT)) ||
                       ((cfg.stop_mode == lfpd_pkg::STOP_CROSS) && cross_seen));

    assign status.halt    = latched_reg || set_stop;
    assign status.latched = latched_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            latched_reg <= 1'b0;
        end
        else if (step)
        begin
            if (!latched_reg && junction_mode && sample_tick)
                count_reg <= count_next;
            if (set_stop)
                latched_reg <= 1'b1;
        end
    end

endmodule

/* hw/rtl/lfpd_pd.sv */
module lfpd_pd #(
    parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lfpd_pkg::cfg_t                       cfg,
    input  logic [SAMPLE_BITS-1:0]               left_sample,
    input  logic [SAMPLE_BITS-1:0]               right_sample,
    input  logic                                 update,
    output logic signed [lfpd_pkg::DRIVE_BITS-1:0] left_drive,
    output logic signed [lfpd_pkg::DRIVE_BITS-1:0] right_drive
);

    localparam int EB  = lfpd_pkg::ERR_BITS;
    localparam int MW  = EB - 1;               // error magnitude bits
    localparam int SH  = 14 - SAMPLE_BITS;     // error = mag * 19 * 2^SH
    localparam int GB  = lfpd_pkg::GAIN_BITS;
    localparam int PW  = EB + GB + 3;          // pd sum width
    localparam int CRW = PW - 16;              // correction width
    localparam int DW  = CRW + 1;              // drive before clamp

    logic signed [EB-1:0]      prev_err_reg;
    logic [SAMPLE_BITS-1:0]    a, b, mag;
    logic                      neg;
    logic [SAMPLE_BITS+4:0]    mag19;
    logic [MW-1:0]             e_mag;
    logic signed [EB-1:0]      err;
    logic                      in_dead;
    logic [GB-1:0]             kp, kd;
    logic signed [EB:0]        diff;
    logic signed [EB+GB:0]     p_term;
    logic signed [EB+GB+1:0]   d_term;
    logic signed [PW-1:0]      pd;
    logic signed [PW-1:0]      pd_bias;
    logic signed [CRW-1:0]     corr;
    logic signed [DW-1:0]      speed_s, ld_raw, rd_raw;

    function automatic logic signed [lfpd_pkg::DRIVE_BITS-1:0] clamp(
        input logic signed [DW-1:0] v);
        logic signed [lfpd_pkg::DRIVE_BITS-1:0] r;
        if (v > DW'(lfpd_pkg::DRIVE_MAX))
            r = lfpd_pkg::DRIVE_BITS'(lfpd_pkg::DRIVE_MAX);
        else if (v < -DW'(lfpd_pkg::DRIVE_MAX))
            r = -lfpd_pkg::DRIVE_BITS'(lfpd_pkg::DRIVE_MAX);
        else
            r = v[lfpd_pkg::DRIVE_BITS-1:0];
        return r;
    endfunction

    // steering error in q8, sign by line polarity
    assign a     = cfg.line_polarity ? left_sample : right_sample;
    assign b     = cfg.line_polarity ? right_sample : left_sample;
    assign neg   = a < b;
    assign mag   = neg ? (b - a) : (a - b);
    assign mag19 = (SAMPLE_BITS+5)'({mag, 4'b0}) + (SAMPLE_BITS+5)'({mag, 1'b0}) +
                   (SAMPLE_BITS+5)'(mag);
    assign e_mag = MW'(mag19) << SH;

    always_comb
    begin
        if (cfg.gain_source)
        begin
            kp      = lfpd_pkg::builtin_kp(cfg.base_speed);
            kd      = lfpd_pkg::builtin_kd(cfg.base_speed, cfg.line_polarity);
            in_dead = e_mag < MW'(lfpd_pkg::DEAD_ZONE_BUILTIN);
        end
        else
        begin
            kp      = cfg.prop_gain;
            kd      = cfg.deriv_gain;
            in_dead = e_mag < MW'(lfpd_pkg::DEAD_ZONE_REG);
        end
    end

    assign err = in_dead ? '0 : (neg ? -$signed({1'b0, e_mag}) : $signed({1'b0, e_mag}));

    // pd sum, two independent multiplies
    assign diff    = (EB+1)'(err) - (EB+1)'(prev_err_reg);
    assign p_term  = (EB+GB+1)'($signed({1'b0, kp})) * (EB+GB+1)'(err);
    assign d_term  = (EB+GB+2)'($signed({1'b0, kd})) * (EB+GB+2)'(diff);
    assign pd      = PW'(p_term) + PW'(d_term);

    // divide by 65536 truncating toward zero
    assign pd_bias = pd + (pd[PW-1] ? PW'(65535) : PW'(0));
    assign corr    = pd_bias[PW-1:16];

    assign speed_s = $signed({{(DW-lfpd_pkg::SPEED_BITS){1'b0}}, cfg.base_speed});
    assign ld_raw  = speed_s - DW'(corr);
    assign rd_raw  = -(speed_s + DW'(corr));

    assign left_drive  = clamp(ld_raw);
    assign right_drive = clamp(rd_raw);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_err_reg <= '0;
        else if (update)
            prev_err_reg <= err;
    end

endmodule

/* hw/rtl/line_follow_pd_drive_core.sv */
// two-sensor pd line follower: each s_ beat carries a left/right grey-sensor
// pair and a sampling-tick flag; each m_ beat carries the left and right motor
// drives (signed, clamped to +-255) and a halted flag. one result per input
// beat, in order. a beat is registered at the input, worked in one pass of
// logic (error, dead zone, two gain multiplies, truncation, clamp, stop
// detect) and registered at the output, and the block takes one beat every
// cycle; the only stall comes from m_tready held low with both stages full.
// configure through apb while the stream is idle. once a stop is latched
// every later beat reads zero drives with halted set, until reset.
`include "line_follow_pd_drive_core_macros.svh"

module line_follow_pd_drive_core #(
    parameter int SAMPLE_BITS   = lfpd_pkg::SAMPLE_BITS_DEF,
    parameter int CONFIRM_TICKS = lfpd_pkg::CONFIRM_TICKS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    // apb configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [lfpd_pkg::ADDR_BITS-1:0]         paddr,
    input  logic [lfpd_pkg::DATA_BITS-1:0]         pwdata,
    output logic [lfpd_pkg::DATA_BITS-1:0]         prdata,
    output logic                                   pready,

    // sample stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // left_sample, right_sample
    input  logic [0:0]                             s_tuser,   // sample_tick

    // drive stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [lfpd_pkg::OUT_TDATA_BITS-1:0]    m_tdata,   // left_drive, right_drive
    output logic [0:0]                             m_tuser    // halted
);

    localparam int DB = lfpd_pkg::DRIVE_BITS;

    lfpd_pkg::cfg_t         cfg;
    lfpd_pkg::stop_status_t stop_st;

    // input stage
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_left_reg, in_right_reg;
    logic                   in_tick_reg;

    // output stage
    logic                   out_valid_reg;
    logic signed [DB-1:0]   out_left_reg, out_right_reg;
    logic                   out_halt_reg;

    logic                   in_take, advance, step;
    logic signed [DB-1:0]   pd_left, pd_right;

    // handshake: the output register frees itself when taken, so the input
    // stage moves forward whenever the output is empty or draining
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    lfpd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // junction and crossroads stop detect
    lfpd_stop #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .CONFIRM_TICKS (CONFIRM_TICKS)
    ) u_stop (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .left_sample  (in_left_reg),
        .right_sample (in_right_reg),
        .sample_tick  (in_tick_reg),
        .step         (step),
        .status       (stop_st)
    );

    // pd steering; previous error only moves on beats that are not stopped
    lfpd_pd #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_pd (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .left_sample  (in_left_reg),
        .right_sample (in_right_reg),
        .update       (step && !stop_st.halt),
        .left_drive   (pd_left),
        .right_drive  (pd_right)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (step)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_left_reg  <= s_tdata[SAMPLE_BITS-1:0];
            in_right_reg <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            in_tick_reg  <= s_tuser[0];
        end
        if (step)
        begin
            out_left_reg  <= stop_st.halt ? '0 : pd_left;
            out_right_reg <= stop_st.halt ? '0 : pd_right;
            out_halt_reg  <= stop_st.halt;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lfpd_pkg::OUT_TDATA_BITS - 2*DB){1'b0}}, out_right_reg, out_left_reg};
    assign m_tuser  = out_halt_reg;

    // a halted beat always carries zero drives
    `LFPD_ASSERT_IMPL(a_halt_zero, m_tvalid && m_tuser[0], m_tdata[2*DB-1:0] == '0)
    // clamp never lets the most negative code through
    `LFPD_ASSERT_IMPL(a_clamp, m_tvalid,
        (m_tdata[DB-1:0] != {1'b1, {(DB-1){1'b0}}}) &&
        (m_tdata[2*DB-1:DB] != {1'b1, {(DB-1){1'b0}}}))
    // once latched the stop stays latched
    `LFPD_ASSERT_NEXT(a_latch_holds, stop_st.latched, stop_st.latched)
    // a latched stop forces the halt of every beat
    `LFPD_ASSERT_IMPL(a_latch_halts, stop_st.latched, stop_st.halt)
    // a beat leaving the input stage lands in the output register
    `LFPD_ASSERT_NEXT(a_step_lands, step, m_tvalid)

endmodule

/* verif/line_follow_pd_drive_core_test.sv */
module line_follow_pd_drive_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lfpd_pkg::*;

    localparam int SBITS          = SAMPLE_BITS_DEF;
    localparam int IN_BITS        = ((2 * SBITS + 7) / 8) * 8;
    localparam int CONFIRM_TICKS  = CONFIRM_TICKS_DEF;
    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 6;      // two-stage pipe plus margin
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no beat on either side
    localparam int MAX_REPORTS    = 60;
    localparam int PHASE_ITEMS    = 108;
    localparam int RANDOM_PHASES  = 12;
    localparam int SAMPLE_MAX     = (1 << SBITS) - 1;

    // q8 steering error per count of sample difference at 10-bit samples
    localparam longint ERR_PER_COUNT = 304;

    typedef struct {
        logic [SBITS-1:0] left;
        logic [SBITS-1:0] right;
        logic             tick;
    } sample_beat_t;

    typedef struct {
        logic signed [DRIVE_BITS-1:0] left;
        logic signed [DRIVE_BITS-1:0] right;
        logic                         halted;
    } drive_beat_t;

    // clock, reset and block inputs, all known from time zero
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_BITS-1:0] s_tdata = '0;    // left_sample, right_sample
    logic [0:0]         s_tuser = '0;    // sample_tick

    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;  // left_drive, right_drive
    logic [0:0]                m_tuser;  // halted

    line_follow_pd_drive_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    // sample beats waiting to be sent, and drive beats waiting to arrive
    sample_beat_t sample_pending[$];
    drive_beat_t  drive_expect[$];

    // predictor copy of the registers and the block state
    cfg_t   cfg = '0;
    longint prev_error = 0;
    int     junction_run = 0;
    logic   halt_latched = 1'b0;

    // generator-side shadow of the stop logic, keeps random phases from latching
    int   gen_run = 0;
    logic gen_halted = 1'b0;

    sample_beat_t drv_beat;
    logic         sample_taken = 1'b0;
    int           idle_pct = 24;
    int           stall_pct = 24;
    int           queued_total = 0;
    int           accepted_total = 0;
    int           results_seen = 0;
    int           quiet_cycles = 0;
    int           mismatch_count = 0;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    // sample on the watched side shows a junction mark
    function automatic logic junction_hit(input logic pol, input logic [SBITS-1:0] s);
        return pol ? (s > TH_LIGHT) : (s < TH_DARK);
    endfunction

    function automatic logic cross_hit(input logic pol, input logic [SBITS-1:0] ls,
                                       input logic [SBITS-1:0] rs);
        return pol ? (ls > TH_CROSS && rs > TH_CROSS) : (ls < TH_CROSS && rs < TH_CROSS);
    endfunction

    function automatic logic signed [DRIVE_BITS-1:0] clamp_drive(input longint v);
        if (v > DRIVE_MAX)
            return DRIVE_BITS'(DRIVE_MAX);
        if (v < -DRIVE_MAX)
            return DRIVE_BITS'(-DRIVE_MAX);
        return DRIVE_BITS'(v);
    endfunction

    // expected drive beat for one accepted sample beat, advances the state
    task automatic predict_drive(input sample_beat_t beat);
        drive_beat_t      res;
        logic [SBITS-1:0] lead;
        logic [SBITS-1:0] trail;
        longint           diff;
        longint           e_mag;
        longint           err;
        longint           kp;
        longint           kd;
        longint           dz;
        longint           pd;
        longint           corr;
        if (!halt_latched) begin
            if (cfg.stop_mode == STOP_LEFT || cfg.stop_mode == STOP_RIGHT) begin
                // junction confirm only moves on a tick
                if (beat.tick) begin
                    if (junction_hit(cfg.line_polarity,
                                     cfg.stop_mode == STOP_LEFT ? beat.left : beat.right)) begin
                        if (junction_run < 7)
                            junction_run++;
                    end
                    else
                        junction_run = 0;
                    if (junction_run >= CONFIRM_TICKS)
                        halt_latched = 1'b1;
                end
            end
            else if (cfg.stop_mode == STOP_CROSS && cross_hit(cfg.line_polarity, beat.left,
                                                               beat.right))
                halt_latched = 1'b1;
        end
        if (halt_latched) begin
            // stopped: zero drives, pd state frozen
            res.left = '0;
            res.right = '0;
            res.halted = 1'b1;
        end
        else begin
            lead = cfg.line_polarity ? beat.left : beat.right;
            trail = cfg.line_polarity ? beat.right : beat.left;
            diff = longint'(lead) - longint'(trail);
            e_mag = (diff < 0 ? -diff : diff) * ERR_PER_COUNT;
            err = diff < 0 ? -e_mag : e_mag;
            if (!cfg.gain_source) begin
                kp = cfg.prop_gain;
                kd = cfg.deriv_gain;
                dz = DEAD_ZONE_REG;
            end
            else begin
                // speed-banded built-in gains, q8.8
                dz = DEAD_ZONE_BUILTIN;
                if (cfg.base_speed <= 64) begin
                    kp = 38;
                    kd = cfg.line_polarity ? 1024 : 768;
                end
                else if (cfg.base_speed <= 128) begin
                    kp = 77;
                    kd = cfg.line_polarity ? 2304 : 1536;
                end
                else begin
                    kp = 141;
                    kd = cfg.line_polarity ? 4608 : 3072;
                end
            end
            if (e_mag < dz)
                err = 0;
            pd = kp * err + kd * (err - prev_error);
            corr = pd / 65536;  // truncates toward zero
            res.left = clamp_drive(longint'(cfg.base_speed) - corr);
            res.right = clamp_drive(-(longint'(cfg.base_speed) + corr));
            res.halted = 1'b0;
            prev_error = err;
        end
        drive_expect.push_back(res);
    endtask

    // sample driver: new beat or idle at the falling edge, valid held until taken
    always @(negedge clk) begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || sample_taken) begin
            if (sample_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
                drv_beat = sample_pending.pop_front();
                s_tdata <= IN_BITS'({drv_beat.right, drv_beat.left});
                s_tuser <= drv_beat.tick;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
        sample_taken = 1'b0;
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor: predicts on each sample beat, checks each drive beat, and a watchdog
    always @(posedge clk) begin
        drive_beat_t want;
        logic signed [DRIVE_BITS-1:0] got_left;
        logic signed [DRIVE_BITS-1:0] got_right;
        if (rst_n) begin
            quiet_cycles++;
            if (s_tvalid && s_tready) begin
                predict_drive(drv_beat);
                sample_taken = 1'b1;
                accepted_total++;
                quiet_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                quiet_cycles = 0;
                got_left = m_tdata[DRIVE_BITS-1:0];
                got_right = m_tdata[2*DRIVE_BITS-1:DRIVE_BITS];
                if (drive_expect.size() == 0)
                    report_mismatch($sformatf("drive beat %0d with nothing expected",
                                              results_seen));
                else begin
                    want = drive_expect.pop_front();
                    if (got_left !== want.left)
                        report_mismatch($sformatf("beat %0d left_drive %0d, want %0d",
                                                  results_seen, got_left, want.left));
                    if (got_right !== want.right)
                        report_mismatch($sformatf("beat %0d right_drive %0d, want %0d",
                                                  results_seen, got_right, want.right));
                    if (m_tuser[0] !== want.halted)
                        report_mismatch($sformatf("beat %0d halted %b, want %b",
                                                  results_seen, m_tuser[0], want.halted));
                end
                results_seen++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("line_follow_pd_drive_core_test: errors");
                $finish;
            end
        end
    end

    // apb write, predictor register updated at the access edge
    task automatic apb_write(input logic [2:0] idx, input logic [DATA_BITS-1:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_LINE_POLARITY: cfg.line_polarity = value[0];
            REG_BASE_SPEED:    cfg.base_speed = value[SPEED_BITS-1:0];
            REG_PROP_GAIN:     cfg.prop_gain = value[GAIN_BITS-1:0];
            REG_DERIV_GAIN:    cfg.deriv_gain = value[GAIN_BITS-1:0];
            REG_GAIN_SOURCE:   cfg.gain_source = value[0];
            REG_STOP_MODE:     cfg.stop_mode = value[1:0];
            default: ;
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_config(input logic pol, input logic [SPEED_BITS-1:0] speed,
                              input logic [GAIN_BITS-1:0] kp, input logic [GAIN_BITS-1:0] kd,
                              input logic gsrc, input logic [1:0] mode);
        apb_write(REG_LINE_POLARITY, DATA_BITS'(pol));
        apb_write(REG_BASE_SPEED, DATA_BITS'(speed));
        apb_write(REG_PROP_GAIN, DATA_BITS'(kp));
        apb_write(REG_DERIV_GAIN, DATA_BITS'(kd));
        apb_write(REG_GAIN_SOURCE, DATA_BITS'(gsrc));
        apb_write(REG_STOP_MODE, DATA_BITS'(mode));
    endtask

    // all sent beats taken and answered, then let the pipe settle
    task automatic wait_drained();
        while (accepted_total != queued_total || drive_expect.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // queue one sample beat; unless a stop is wanted, a beat that would latch is bent
    task automatic queue_sample(input logic [SBITS-1:0] ls, input logic [SBITS-1:0] rs,
                                input logic tick, input logic may_halt);
        sample_beat_t beat;
        logic         lr_mode;
        lr_mode = (cfg.stop_mode == STOP_LEFT || cfg.stop_mode == STOP_RIGHT);
        if (!gen_halted && !may_halt) begin
            if (lr_mode && tick && gen_run + 1 >= CONFIRM_TICKS &&
                junction_hit(cfg.line_polarity, cfg.stop_mode == STOP_LEFT ? ls : rs)) begin
                // last confirming tick turned into a plain floor reading
                if (cfg.stop_mode == STOP_LEFT)
                    ls = cfg.line_polarity ? SBITS'($urandom_range(TH_LIGHT))
                                           : SBITS'($urandom_range(SAMPLE_MAX, TH_DARK));
                else
                    rs = cfg.line_polarity ? SBITS'($urandom_range(TH_LIGHT))
                                           : SBITS'($urandom_range(SAMPLE_MAX, TH_DARK));
            end
            if (cfg.stop_mode == STOP_CROSS && cross_hit(cfg.line_polarity, ls, rs))
                rs = cfg.line_polarity ? SBITS'($urandom_range(TH_CROSS))
                                       : SBITS'($urandom_range(SAMPLE_MAX, TH_CROSS));
        end
        if (!gen_halted) begin
            if (lr_mode && tick) begin
                if (junction_hit(cfg.line_polarity, cfg.stop_mode == STOP_LEFT ? ls : rs)) begin
                    if (gen_run < 7)
                        gen_run++;
                end
                else
                    gen_run = 0;
                if (gen_run >= CONFIRM_TICKS)
                    gen_halted = 1'b1;
            end
            else if (cfg.stop_mode == STOP_CROSS && cross_hit(cfg.line_polarity, ls, rs))
                gen_halted = 1'b1;
        end
        beat.left = ls;
        beat.right = rs;
        beat.tick = tick;
        sample_pending.push_back(beat);
        queued_total++;
    endtask

    // readings bunched at the extremes and around each threshold
    function automatic logic [SBITS-1:0] pick_sample();
        case ($urandom_range(9))
            0: return '0;
            1: return SBITS'(SAMPLE_MAX);
            2: return SBITS'(TH_DARK - 2 + $urandom_range(4));
            3: return SBITS'(TH_LIGHT - 2 + $urandom_range(4));
            4: return SBITS'(TH_CROSS - 2 + $urandom_range(4));
            default: return SBITS'($urandom_range(SAMPLE_MAX));
        endcase
    endfunction

    function automatic logic [SBITS-1:0] junction_value(input logic pol);
        return pol ? SBITS'($urandom_range(SAMPLE_MAX, TH_LIGHT + 1))
                   : SBITS'($urandom_range(TH_DARK - 1));
    endfunction

    function automatic logic [GAIN_BITS-1:0] pick_gain();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? '1 : '0;
            3: return GAIN_BITS'($urandom);
            default: return GAIN_BITS'($urandom_range(2047));
        endcase
    endfunction

    task automatic queue_random_samples(input int count);
        logic [SBITS-1:0] ls;
        logic [SBITS-1:0] rs;
        logic             tick;
        int               v;
        repeat (count) begin
            ls = pick_sample();
            if ($urandom_range(2) == 0) begin
                // nearly balanced pair, works the dead zone edges
                v = int'(ls) + int'($urandom_range(12)) - 6;
                rs = SBITS'(v < 0 ? 0 : (v > SAMPLE_MAX ? SAMPLE_MAX : v));
            end
            else
                rs = pick_sample();
            tick = 1'($urandom_range(1));
            // in junction modes, half the ticks carry a junction mark to build runs
            if (tick && $urandom_range(1)) begin
                if (cfg.stop_mode == STOP_LEFT)
                    ls = junction_value(cfg.line_polarity);
                else if (cfg.stop_mode == STOP_RIGHT)
                    rs = junction_value(cfg.line_polarity);
            end
            queue_sample(ls, rs, tick, 1'b0);
        end
    endtask

    initial begin
        logic                  pol;
        logic [SPEED_BITS-1:0] speed;
        logic [GAIN_BITS-1:0]  kp;
        logic [GAIN_BITS-1:0]  kd;
        logic                  gsrc;
        logic [1:0]            mode;
        int                    kind;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // register gains: full-scale pairs and both sides of the dead zone
        set_config(1'b0, 8'd100, 16'h0100, 16'h0080, 1'b0, STOP_NEVER);
        queue_sample(10'd0, 10'd0, 1'b0, 1'b0);
        queue_sample(10'd1023, 10'd0, 1'b1, 1'b0);
        queue_sample(10'd0, 10'd1023, 1'b0, 1'b0);
        queue_sample(10'd1023, 10'd1023, 1'b1, 1'b0);
        queue_sample(10'd500, 10'd504, 1'b0, 1'b0);
        queue_sample(10'd500, 10'd505, 1'b1, 1'b0);
        queue_sample(10'd504, 10'd500, 1'b0, 1'b0);
        queue_sample(10'd505, 10'd500, 1'b0, 1'b0);
        wait_drained();

        // built-in gains, light line, narrow dead zone
        set_config(1'b1, 8'd200, 16'h0000, 16'h0000, 1'b1, STOP_NEVER);
        queue_sample(10'd0, 10'd1023, 1'b0, 1'b0);
        queue_sample(10'd1023, 10'd0, 1'b1, 1'b0);
        queue_sample(10'd500, 10'd501, 1'b0, 1'b0);
        queue_sample(10'd500, 10'd502, 1'b0, 1'b0);
        queue_sample(10'd502, 10'd500, 1'b1, 1'b0);
        wait_drained();

        // left junction run of four ticks, a held count, then cleared on the threshold
        set_config(1'b0, 8'd60, 16'd300, 16'd300, 1'b0, STOP_LEFT);
        queue_sample(10'd249, 10'd600, 1'b1, 1'b0);
        queue_sample(10'd0, 10'd0, 1'b0, 1'b0);
        queue_sample(10'd249, 10'd600, 1'b1, 1'b0);
        queue_sample(10'd249, 10'd600, 1'b1, 1'b0);
        queue_sample(10'd249, 10'd600, 1'b1, 1'b0);
        queue_sample(10'd250, 10'd600, 1'b1, 1'b0);
        wait_drained();

        // right junction on a light line, just over and at the threshold
        set_config(1'b1, 8'd60, 16'd300, 16'd300, 1'b0, STOP_RIGHT);
        queue_sample(10'd0, 10'd401, 1'b1, 1'b0);
        queue_sample(10'd0, 10'd400, 1'b1, 1'b0);
        wait_drained();

        // crossroads near misses
        set_config(1'b0, 8'd60, 16'd300, 16'd300, 1'b0, STOP_CROSS);
        queue_sample(10'd329, 10'd330, 1'b0, 1'b0);
        queue_sample(10'd330, 10'd329, 1'b1, 1'b0);
        wait_drained();

        // random phases; the first few pin the register extremes and speed bands
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            pol = 1'($urandom_range(1));
            speed = $urandom_range(3) == 0 ? SPEED_BITS'($urandom_range(1) ? 255 : 0)
                                           : SPEED_BITS'($urandom_range(255));
            kp = pick_gain();
            kd = pick_gain();
            gsrc = 1'($urandom_range(1));
            mode = 2'($urandom_range(3));
            case (p)
                0: {pol, speed, kp, kd, gsrc, mode} = {1'b1, 8'd255, 16'hffff, 16'hffff,
                                                      1'b0, STOP_NEVER};
                1: {pol, speed, kp, kd, gsrc, mode} = {1'b0, 8'd0, 16'h0000, 16'hffff,
                                                      1'b0, STOP_LEFT};
                2: {pol, speed, gsrc, mode} = {1'b0, 8'd64, 1'b1, STOP_RIGHT};
                3: {pol, speed, gsrc, mode} = {1'b1, 8'd65, 1'b1, STOP_CROSS};
                4: {pol, speed, gsrc, mode} = {1'b1, 8'd128, 1'b1, STOP_LEFT};
                5: {pol, speed, gsrc, mode} = {1'b0, 8'd129, 1'b1, STOP_NEVER};
                default: ;
            endcase
            // one phase runs flat out on both sides
            idle_pct = (p == 6) ? 0 : 24;
            stall_pct = (p == 6) ? 0 : 24;
            set_config(pol, speed, kp, kd, gsrc, mode);
            queue_random_samples(PHASE_ITEMS);
            wait_drained();
        end
        idle_pct = 24;
        stall_pct = 24;

        // closing phase: latch a stop of a random kind, then show it sticks
        kind = $urandom_range(2);
        pol = 1'($urandom_range(1));
        mode = (kind == 0) ? STOP_LEFT : ((kind == 1) ? STOP_RIGHT : STOP_CROSS);
        set_config(pol, 8'd150, 16'd600, 16'd1200, 1'b0, mode);
        queue_random_samples($urandom_range(4));
        if (mode == STOP_CROSS) begin
            if (pol)
                queue_sample(SBITS'($urandom_range(SAMPLE_MAX, TH_CROSS + 1)),
                             SBITS'($urandom_range(SAMPLE_MAX, TH_CROSS + 1)), 1'b0, 1'b1);
            else
                queue_sample(SBITS'($urandom_range(TH_CROSS - 1)),
                             SBITS'($urandom_range(TH_CROSS - 1)), 1'b0, 1'b1);
        end
        else begin
            // confirming ticks, with tick-free beats between that must not disturb the count
            repeat (CONFIRM_TICKS) begin
                repeat ($urandom_range(2))
                    queue_sample(pick_sample(), pick_sample(), 1'b0, 1'b1);
                if (mode == STOP_LEFT)
                    queue_sample(junction_value(pol), pick_sample(), 1'b1, 1'b1);
                else
                    queue_sample(pick_sample(), junction_value(pol), 1'b1, 1'b1);
            end
        end
        queue_random_samples(20);
        wait_drained();

        // a new stop mode and gains do not release the latch
        set_config(~pol, 8'd255, pick_gain(), pick_gain(), 1'b1, STOP_NEVER);
        queue_random_samples(10);
        wait_drained();

        if (mismatch_count == 0)
            $display("line_follow_pd_drive_core_test: clean");
        else
            $display("line_follow_pd_drive_core_test: errors");
        $finish;
    end

endmodule
